/* src/min_coin_change_macros.svh */
// Assertion macros for the coin change RTL.
// Sampled on clk, disabled while rst is high; empty for synthesis.
`ifndef MIN_COIN_CHANGE_MACROS_SVH
`define MIN_COIN_CHANGE_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge.
`define MCC_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("coin change assertion failed");

// Same-cycle implication.
`define MCC_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coin change implication failed");

// Next-cycle implication.
`define MCC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coin change next-cycle check failed");

`else

`define MCC_CHECK(lbl, cond)
`define MCC_IMPLY(lbl, ante, cons)
`define MCC_NEXT(lbl, ante, cons)

`endif

`endif

/* src/mcc_pkg.sv */
// Shared types and constants for the coin change block.
// No dependencies; imported by the interfaces and all modules.
package mcc_pkg;

  localparam int AMOUNT_W  = 10;
  localparam int TOTAL_W   = 10;
  localparam int COIN_W    = 10;
  localparam int CNT_W     = 3;
  localparam int ENTRY_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int COIN_REGS = 4;
  localparam int COIN_IDX_W = 2;

  localparam logic [ENTRY_W-1:0] UNREACHABLE = 11'h7FF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_3 = 3'd4;

  // reset values of the registers
  localparam logic [CNT_W-1:0]  RST_COIN_COUNT   = 3'd4;
  localparam logic [COIN_W-1:0] RST_COIN_VALUE_0 = 10'd1;
  localparam logic [COIN_W-1:0] RST_COIN_VALUE_1 = 10'd3;
  localparam logic [COIN_W-1:0] RST_COIN_VALUE_2 = 10'd7;
  localparam logic [COIN_W-1:0] RST_COIN_VALUE_3 = 10'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } mcc_state_t;

  typedef struct packed {
    logic load;   // latch a new request
    logic scan;   // issue one table read for the current coin
    logic flush;  // write the finished entry, step the amount
    logic emit;   // load the result register
  } mcc_cmd_t;

  typedef struct packed {
    logic trivial;      // incoming amount is zero or beyond the table
    logic last_coin;
    logic last_amount;
    logic out_busy;     // result register full and stalled
  } mcc_status_t;

endpackage

/* src/mcc_req_if.sv */
// Request channel: one target amount per transfer.
// Depends on mcc_pkg for the field width.
interface mcc_req_if import mcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

/* src/mcc_rsp_if.sv */
// Result channel: found flag and minimum coin count.
// Depends on mcc_pkg for the field width.
interface mcc_rsp_if import mcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [TOTAL_W-1:0] coin_total;

  modport source (output valid, output found, output coin_total, input ready);
  modport sink   (input valid, input found, input coin_total, output ready);
endinterface

/* src/mcc_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on mcc_pkg for the widths.
interface mcc_cfg_if import mcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/min_coin_change.sv */
// Top level of the minimum coin change block.
// Depends on mcc_pkg, the channel interfaces, mcc_ctrl and mcc_datapath.
//
// Usage:
//   req  - one target amount per request (valid/ready).
//   rsp  - one result per request: found flag and fewest coin count.
//   cfg  - register writes (index, data); always ready. Write only while
//          the block is idle. Index 0 is the coin count, 1..4 the values.
// Operation: the table is filled bottom-up from amount 1 to the target.
//   Each entry scans the coin slots in turn (min(4, NUM_COINS) slots,
//   one table read each through the single read port), then writes the
//   entry. Amount zero or above MAX_AMOUNT skips the fill and goes
//   straight to the result. One item is in work at a time.
// The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the next finished result holds in the
//   datapath until the register frees up.
// Reset (rst, synchronous) restores the register defaults and empties the
//   channels. The table needs no clearing: every entry is written before
//   it is read within a request.
module min_coin_change import mcc_pkg::*; #(
  parameter int NUM_COINS  = 4,
  parameter int MAX_AMOUNT = 1023
) (
  input logic      clk,
  input logic      rst,
  mcc_req_if.sink  req,
  mcc_rsp_if.source rsp,
  mcc_cfg_if.sink  cfg
);

  mcc_cmd_t    cmd;
  mcc_status_t status;

  // config writes never stall
  assign cfg.ready = 1'b1;

  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcc_datapath #(
    .NUM_COINS  (NUM_COINS),
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_amount     (req.amount),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_coin_total (rsp.coin_total)
  );

endmodule

/* src/mcc_ctrl.sv */
// Sequencer for the coin change table fill.
// Depends on mcc_pkg; drives mcc_datapath through mcc_cmd_t.
module mcc_ctrl import mcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  mcc_status_t status,
  output mcc_cmd_t    cmd
);

  mcc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = status.trivial ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last_coin) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = status.last_amount ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/mcc_datapath.sv */
// Config registers, best-count table, min/compare unit and result register.
// Depends on mcc_pkg and the assertion macros; commanded by mcc_ctrl.
`include "min_coin_change_macros.svh"

module mcc_datapath import mcc_pkg::*; #(
  parameter int NUM_COINS  = 4,
  parameter int MAX_AMOUNT = 1023
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcc_cmd_t             cmd,
  output mcc_status_t          status,
  input  logic [AMOUNT_W-1:0]  req_amount,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COIN_W-1:0]    cfg_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic                 rsp_found,
  output logic [TOTAL_W-1:0]   rsp_coin_total
);

  // largest amount the table serves, bounded by the input field
  localparam int LIMIT = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
  localparam int DEPTH = LIMIT + 1;
  localparam int A_W   = $clog2(DEPTH);
  localparam int NC    = (NUM_COINS < COIN_REGS) ? NUM_COINS : COIN_REGS;
  localparam int J_W   = (NC > 1) ? $clog2(NC) : 1;

  logic [CNT_W-1:0]  coin_count;
  logic [COIN_W-1:0] coin_value [COIN_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count    <= RST_COIN_COUNT;
      coin_value[0] <= RST_COIN_VALUE_0;
      coin_value[1] <= RST_COIN_VALUE_1;
      coin_value[2] <= RST_COIN_VALUE_2;
      coin_value[3] <= RST_COIN_VALUE_3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COIN_COUNT:   coin_count    <= cfg_data[CNT_W-1:0];
        CFG_COIN_VALUE_0: coin_value[0] <= cfg_data;
        CFG_COIN_VALUE_1: coin_value[1] <= cfg_data;
        CFG_COIN_VALUE_2: coin_value[2] <= cfg_data;
        CFG_COIN_VALUE_3: coin_value[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_use;
  assign n_use = (coin_count > CNT_W'(NC)) ? CNT_W'(NC) : coin_count;

  logic [A_W-1:0]     target;
  logic [A_W-1:0]     a;
  logic [J_W-1:0]     j;
  logic               oor;
  logic [ENTRY_W-1:0] last_best;
  logic [ENTRY_W-1:0] acc;
  logic               pend_valid;
  logic               pend_zero;
  logic [ENTRY_W-1:0] mem_q;
  logic [ENTRY_W-1:0] best_table [DEPTH];

  // read issue for coin j at amount a
  logic [COIN_W-1:0]   coin;
  logic [AMOUNT_W-1:0] a_ext;
  logic                use_coin;
  logic [A_W-1:0]      rd_addr;

  assign coin     = coin_value[COIN_IDX_W'(j)];
  assign a_ext    = AMOUNT_W'(a);
  assign use_coin = (CNT_W'(j) < n_use) && (coin != '0) && (coin <= a_ext);
  assign rd_addr  = A_W'(a_ext - coin);

  // entry 0 is always zero and is never stored
  logic [ENTRY_W-1:0] pval;
  logic [ENTRY_W-1:0] low_now;
  logic [ENTRY_W-1:0] entry_new;

  assign pval    = pend_zero ? '0 : mem_q;
  assign low_now = (pend_valid && (pval < acc)) ? pval : acc;

  always_comb begin
    if (low_now == UNREACHABLE) begin
      entry_new = UNREACHABLE;
    end else if (low_now == UNREACHABLE - 1'b1) begin
      entry_new = UNREACHABLE - 1'b1;
    end else begin
      entry_new = low_now + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      mem_q <= best_table[rd_addr];
    end
    if (cmd.flush) begin
      best_table[a] <= entry_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.scan && use_coin;
    end
  end

  always_ff @(posedge clk) begin
    pend_zero <= (coin == a_ext);
    if (cmd.load) begin
      target    <= req_amount[A_W-1:0];
      a         <= A_W'(1);
      j         <= '0;
      oor       <= (req_amount > AMOUNT_W'(LIMIT));
      last_best <= '0;
      acc       <= UNREACHABLE;
    end else if (cmd.scan) begin
      j   <= j + 1'b1;
      acc <= low_now;
    end else if (cmd.flush) begin
      last_best <= entry_new;
      acc       <= UNREACHABLE;
      a         <= a + 1'b1;
      j         <= '0;
    end
  end

  always_comb begin
    status.trivial     = (req_amount == '0) || (req_amount > AMOUNT_W'(LIMIT));
    status.last_coin   = (j == J_W'(NC - 1));
    status.last_amount = (a == target);
    status.out_busy    = rsp_valid && !rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  logic found_now;
  assign found_now = !oor && (last_best != UNREACHABLE);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_found      <= found_now;
      rsp_coin_total <= found_now ? last_best[TOTAL_W-1:0] : '0;
    end
  end

  `MCC_IMPLY(write_in_range, cmd.flush, (a <= target) && (a != '0))
  `MCC_IMPLY(read_below_write, cmd.scan && use_coin, rd_addr < a)
  `MCC_CHECK(no_result_overrun, !cmd.emit || !rsp_valid || rsp_ready)
  `MCC_NEXT(count_bounded, cmd.emit && !oor, AMOUNT_W'(rsp_coin_total) <= AMOUNT_W'(target))

endmodule
